FILE: design/kqsb_pkg.sv
`default_nettype none
package kqsb_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned QidW  = 2;
  localparam int unsigned StatW = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [StatW-1:0] STATUS_OK  = 2'd0;
  localparam logic [StatW-1:0] STATUS_OVF = 2'd1;
  localparam logic [StatW-1:0] STATUS_UNF = 2'd2;

  localparam logic signed [DataW-1:0] UNDERFLOW_WORD = -32'sd1;

  typedef struct packed {
    logic                    operation;
    logic [QidW-1:0]         queue_id;
    logic signed [DataW-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] data_out;
    logic [StatW-1:0]        status;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LINK,
    ST_TIE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic check;
    logic link;
    logic tie;
    logic respond;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fail;
    logic is_deq;
  } stat_t;

endpackage
`default_nettype wire

FILE: design/kqsb_ctrl.sv
`default_nettype none
module kqsb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire kqsb_pkg::stat_t stat_i,
  output kqsb_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  kqsb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kqsb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      kqsb_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = kqsb_pkg::ST_CHECK;
        end
      end
      kqsb_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (stat_i.fail) begin
          cmd_o.respond = 1'b1;
          state_d       = kqsb_pkg::ST_IDLE;
        end else begin
          state_d = kqsb_pkg::ST_LINK;
        end
      end
      kqsb_pkg::ST_LINK: begin
        cmd_o.link = 1'b1;
        if (stat_i.is_deq) begin
          cmd_o.respond = 1'b1;
          state_d       = kqsb_pkg::ST_IDLE;
        end else begin
          state_d = kqsb_pkg::ST_TIE;
        end
      end
      kqsb_pkg::ST_TIE: begin
        cmd_o.tie     = 1'b1;
        cmd_o.respond = 1'b1;
        state_d       = kqsb_pkg::ST_IDLE;
      end
      default: begin
        state_d = kqsb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/kqsb_datapath.sv
`default_nettype none
module kqsb_datapath #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned QUEUES = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire kqsb_pkg::in_t   item_i,
  input  wire kqsb_pkg::cmd_t  cmd_i,
  output kqsb_pkg::stat_t      stat_o,
  output logic                 done_o,
  output kqsb_pkg::out_t       result_o
);

  localparam int unsigned PW  = $clog2(SLOTS + 1);
  localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned QIW = (QW > kqsb_pkg::QidW) ? QW : kqsb_pkg::QidW;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  // Captured item and its queue index.
  kqsb_pkg::in_t item_q;
  logic [QIW-1:0] qin_ext, qcur_ext;
  logic [QW-1:0]  qin, qcur;
  logic           q_ok;

  assign qin_ext  = QIW'(item_i.queue_id);
  assign qin      = qin_ext[QW-1:0];
  assign qcur_ext = QIW'(item_q.queue_id);
  assign qcur     = qcur_ext[QW-1:0];
  assign q_ok     = {30'd0, item_q.queue_id} < QUEUES;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
  end

  // Slot taken from or returned to the free list by the current item.
  logic [PW-1:0] link_addr_q;

  // Head and tail pointer stores, with a valid bit per queue.
  logic [PW-1:0]     head_mem [QUEUES];
  logic [PW-1:0]     tail_mem [QUEUES];
  logic [QUEUES-1:0] hvalid_q, tvalid_q;
  logic [PW-1:0]     head_rd_q, tail_rd_q;
  logic              hv_rd_q, tv_rd_q;
  logic [PW-1:0]     head_eff, tail_eff;
  logic              head_we, tail_we;
  logic [PW-1:0]     head_wd;

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[qcur] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[qcur] <= link_addr_q;
    end
    if (cmd_i.capture) begin
      head_rd_q <= head_mem[qin];
      tail_rd_q <= tail_mem[qin];
      hv_rd_q   <= hvalid_q[qin];
      tv_rd_q   <= tvalid_q[qin];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
      tvalid_q <= '0;
    end else begin
      if (head_we) begin
        hvalid_q[qcur] <= 1'b1;
      end
      if (tail_we) begin
        tvalid_q[qcur] <= 1'b1;
      end
    end
  end

  assign head_eff = hv_rd_q ? head_rd_q : NIL;
  assign tail_eff = tv_rd_q ? tail_rd_q : NIL;

  // Free list head and the mark below which link entries have been written.
  // Slots at or above the mark are read as holding their reset link, slot plus one.
  logic [PW-1:0] free_head_q, free_head_d;
  logic [PW-1:0] wm_q, wm_d;
  logic          is_deq;

  assign is_deq = (item_q.operation == kqsb_pkg::OP_DEQ);

  // Link store.
  logic [PW-1:0] link_mem [SLOTS];
  logic [PW-1:0] link_rd_q, link_ra, link_eff;
  logic [PW-1:0] link_wa, link_wd;
  logic          link_we;
  logic [PW-1:0] slot_plus;

  assign link_ra   = is_deq ? head_eff : free_head_q;
  assign slot_plus = PW'(link_addr_q + PW'(1));
  assign link_eff  = (link_addr_q >= wm_q) ? slot_plus : link_rd_q;

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa[SW-1:0]] <= link_wd;
    end
    if (cmd_i.check) begin
      link_rd_q   <= link_mem[link_ra[SW-1:0]];
      link_addr_q <= link_ra;
    end
  end

  // Word store.
  logic signed [kqsb_pkg::DataW-1:0] data_mem [SLOTS];
  logic signed [kqsb_pkg::DataW-1:0] data_rd_q;
  logic                              data_we;

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[free_head_q[SW-1:0]] <= item_q.data_in;
    end
    if (cmd_i.check) begin
      data_rd_q <= data_mem[head_eff[SW-1:0]];
    end
  end

  // Fail check, valid in the check step only.
  logic fail;

  always_comb begin
    if (is_deq) begin
      fail = !q_ok || !(head_eff < NIL);
    end else begin
      fail = !q_ok || !(free_head_q < NIL);
    end
  end

  assign stat_o.fail   = fail;
  assign stat_o.is_deq = is_deq;

  // List updates.
  always_comb begin
    free_head_d = free_head_q;
    wm_d        = wm_q;
    head_we     = 1'b0;
    head_wd     = link_eff;
    tail_we     = 1'b0;
    data_we     = 1'b0;
    link_we     = 1'b0;
    link_wa     = link_addr_q;
    link_wd     = NIL;
    if (cmd_i.link) begin
      if (is_deq) begin
        head_we     = 1'b1;
        head_wd     = link_eff;
        link_we     = 1'b1;
        link_wa     = link_addr_q;
        link_wd     = free_head_q;
        free_head_d = link_addr_q;
      end else begin
        free_head_d = link_eff;
        data_we     = 1'b1;
        tail_we     = 1'b1;
        if (link_addr_q == wm_q) begin
          wm_d = PW'(wm_q + PW'(1));
        end
        if (!(head_eff < NIL)) begin
          head_we = 1'b1;
          head_wd = link_addr_q;
        end else if (tail_eff < NIL) begin
          link_we = 1'b1;
          link_wa = tail_eff;
          link_wd = link_addr_q;
        end
      end
    end else if (cmd_i.tie) begin
      link_we = 1'b1;
      link_wa = link_addr_q;
      link_wd = NIL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      wm_q        <= '0;
    end else begin
      free_head_q <= free_head_d;
      wm_q        <= wm_d;
    end
  end

  // Result register.
  kqsb_pkg::out_t res_d, result_q;
  logic           done_q;
  logic           res_fail;

  assign res_fail = cmd_i.check & fail;

  always_comb begin
    if (is_deq) begin
      if (res_fail) begin
        res_d.data_out = kqsb_pkg::UNDERFLOW_WORD;
        res_d.status   = kqsb_pkg::STATUS_UNF;
      end else begin
        res_d.data_out = data_rd_q;
        res_d.status   = kqsb_pkg::STATUS_OK;
      end
    end else begin
      res_d.data_out = '0;
      res_d.status   = res_fail ? kqsb_pkg::STATUS_OVF : kqsb_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      result_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.respond;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

FILE: design/k_queue_shared_buffer_top.sv
// A successful enqueue passes through the check, link and tie-off states, a successful
// dequeue through check and link, and a rejected item (overflow or underflow) through
// check alone. No new item is taken until the last state is left. The states follow from
// the chain of registered reads of pointer store, then link store, plus one extra write.
// The receiver cannot stall: each result is shown for one cycle with done_o high.
// Reset is asynchronous and active low; all queues are empty and every slot is free.
`default_nettype none
module k_queue_shared_buffer_top #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned QUEUES = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire kqsb_pkg::in_t  item_i,
  output logic                done_o,
  output kqsb_pkg::out_t      result_o
);

  // The controller steps each item through check, link and tie-off phases as it needs them.
  // In the check phase the head and tail of the addressed queue are known and the
  // link and word stores are read; the link phase rewrites the lists; an enqueue
  // then needs a tie-off phase to mark its new slot as the end of the queue, since
  // the link store has a single write port.
  kqsb_pkg::cmd_t  cmd;
  kqsb_pkg::stat_t stat;

  kqsb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // The datapath holds the pointer, link and word stores and the result register.
  // Link entries that were never written are recognised by a high-water mark, so
  // no clearing pass is needed after reset.
  kqsb_datapath #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

FILE: sim/k_queue_shared_buffer_top_tb.sv
`default_nettype none

// Tracks the contents of the shared slot store as the block should hold it: per-queue linked
// lists of slots and one common free list. Each accepted request is applied to this copy and
// the response it must cause is queued until the block shows it.
class shared_queue_tracker;
  int unsigned n_slots;
  int unsigned n_queues;
  int unsigned nil_slot;
  int unsigned head_of[];
  int unsigned tail_of[];
  int unsigned next_of[];
  logic signed [kqsb_pkg::DataW-1:0] word_of[];
  int unsigned free_first;
  kqsb_pkg::out_t due_results[$];
  int unsigned errors;

  function new(int unsigned slots, int unsigned queues);
    n_slots    = slots;
    n_queues   = queues;
    nil_slot   = slots;
    head_of    = new[queues];
    tail_of    = new[queues];
    next_of    = new[slots];
    word_of    = new[slots];
    for (int unsigned i = 0; i < queues; i++) begin
      head_of[i] = nil_slot;
      tail_of[i] = nil_slot;
    end
    // Every slot starts on the free list, in order; the last one ends it.
    for (int unsigned i = 0; i < slots; i++) begin
      next_of[i] = i + 1;
      word_of[i] = '0;
    end
    free_first = 0;
    errors     = 0;
  endfunction

  function kqsb_pkg::out_t apply_request(kqsb_pkg::in_t req);
    kqsb_pkg::out_t rsp;
    int unsigned    q;
    int unsigned    slot;
    q            = int'(req.queue_id);
    rsp.data_out = '0;
    rsp.status   = kqsb_pkg::STATUS_OK;
    if (req.operation == kqsb_pkg::OP_ENQ) begin
      if (q >= n_queues || free_first >= n_slots) begin
        rsp.status = kqsb_pkg::STATUS_OVF;
      end else begin
        slot       = free_first;
        free_first = next_of[slot];
        if (head_of[q] >= n_slots) begin
          head_of[q] = slot;
        end else if (tail_of[q] < n_slots) begin
          next_of[tail_of[q]] = slot;
        end
        next_of[slot] = nil_slot;
        tail_of[q]    = slot;
        word_of[slot] = req.data_in;
      end
    end else begin
      if (q >= n_queues || head_of[q] >= n_slots) begin
        rsp.status   = kqsb_pkg::STATUS_UNF;
        rsp.data_out = kqsb_pkg::UNDERFLOW_WORD;
      end else begin
        // The tail is left stale when the queue empties; the next enqueue resets it.
        slot          = head_of[q];
        head_of[q]    = next_of[slot];
        next_of[slot] = free_first;
        free_first    = slot;
        rsp.data_out  = word_of[slot];
      end
    end
    return rsp;
  endfunction

  function void note_request(kqsb_pkg::in_t req);
    due_results.push_back(apply_request(req));
  endfunction

  function void check_response(kqsb_pkg::out_t got);
    kqsb_pkg::out_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: data_out %0d status %0d", got.data_out, got.status);
      errors++;
      return;
    end
    want = due_results.pop_front();
    if (got.data_out !== want.data_out) begin
      $error("data_out mismatch: expected %0d, actual %0d", want.data_out, got.data_out);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
  endfunction
endclass

module k_queue_shared_buffer_top_tb;

  localparam int unsigned SLOTS          = 16;
  localparam int unsigned QUEUES         = 4;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RANDOM_ITEMS   = 1425;
  // The last stretch of the random part runs without any idling on the sending side.
  localparam int unsigned CALM_TAIL      = 200;
  localparam int unsigned PHASE_LEN      = 32;
  // The slowest item and the longest idle burst both fall well within this limit, so a run
  // of it without a single handshake can only mean that the block has hung.
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned DRAIN_CYCLES   = 8;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  logic           busy;
  kqsb_pkg::in_t  item_i = '0;
  logic           done_o;
  kqsb_pkg::out_t result_o;

  shared_queue_tracker tracker;
  int unsigned         idle_cycles = 0;

  k_queue_shared_buffer_top #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Results cannot be held off, so every cycle with done_o high carries one result. The
  // values are read as they stood just before the edge, since the block updates its
  // outputs only through its own registers at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      tracker.check_response(result_o);
    end
  end

  // The watchdog restarts whenever an item is accepted or a result appears. If the block
  // stops answering altogether, the run ends here rather than hanging.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic kqsb_pkg::in_t make_item(logic op, int unsigned q,
                                              logic [kqsb_pkg::DataW-1:0] word);
    kqsb_pkg::in_t it;
    it.operation = op;
    it.queue_id  = q[kqsb_pkg::QidW-1:0];
    it.data_in   = word;
    return it;
  endfunction

  // Presents one item and holds it until the block takes it, which happens at the first
  // rising edge with start high and busy low. Start is left high when the next item follows
  // at once, so it is never lowered and raised again within one time step.
  task automatic send_item(input kqsb_pkg::in_t it, input int unsigned gap);
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tracker.note_request(it);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [kqsb_pkg::DataW-1:0] corner_words[6];
    int unsigned                enq_pct;
    int unsigned                hot_queue;
    int unsigned                hot_pct;
    int unsigned                gap;
    int unsigned                q;
    bit                         gaps_on;
    logic                       op;
    logic [kqsb_pkg::DataW-1:0] word;

    corner_words[0] = 32'h8000_0000;
    corner_words[1] = 32'h7FFF_FFFF;
    corner_words[2] = 32'h0000_0000;
    corner_words[3] = 32'hFFFF_FFFF;
    corner_words[4] = 32'h5555_5555;
    corner_words[5] = 32'hAAAA_AAAA;
    enq_pct   = 50;
    hot_queue = 0;
    hot_pct   = 0;
    gaps_on   = 1'b0;

    tracker = new(SLOTS, QUEUES);

    // Reset is held low from the start and released on a rising edge.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. First every queue is empty, so each dequeue must underflow and
    // return the all-ones word.
    for (int unsigned i = 0; i < QUEUES; i++) begin
      send_item(make_item(kqsb_pkg::OP_DEQ, i, $urandom()), 0);
    end
    // Fill the whole store across all queues with the extreme words, then one enqueue more,
    // which finds no free slot and must report overflow without changing anything.
    for (int unsigned i = 0; i <= SLOTS; i++) begin
      send_item(make_item(kqsb_pkg::OP_ENQ, i % QUEUES, corner_words[i % 6]), 0);
    end
    // Drain the head of each queue, giving back the first words that were stored.
    for (int unsigned i = 0; i < QUEUES; i++) begin
      send_item(make_item(kqsb_pkg::OP_DEQ, i, $urandom()), 0);
    end

    // Random part. It runs in phases that lean towards enqueues or dequeues, so the store
    // swings between full and empty and both overflow and underflow keep turning up. Some
    // phases crowd one queue so that long chains of linked slots build up and are unwound.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 20;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
        hot_queue = $urandom_range(0, QUEUES - 1);
        hot_pct   = $urandom_range(0, 90);
        gaps_on   = ($urandom_range(0, 2) != 0);
      end
      op = ($urandom_range(0, 99) < enq_pct) ? kqsb_pkg::OP_ENQ : kqsb_pkg::OP_DEQ;
      q  = ($urandom_range(0, 99) < hot_pct) ? hot_queue : $urandom_range(0, QUEUES - 1);
      if ($urandom_range(0, 7) == 0) begin
        word = corner_words[$urandom_range(0, 5)];
      end else begin
        word = $urandom();
      end
      if (gaps_on && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 15);
      end else begin
        gap = 0;
      end
      send_item(make_item(op, q, word), gap);
    end
    start <= 1'b0;

    // Wait for every outstanding result, then a few cycles more in case the block
    // produces anything it should not.
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
